>>> rtl/fsc_pkg.sv
// shared types and constants of the encoder frame statistics collector
package fsc_pkg;

    localparam int QUANT_BINS_DEF = 31;
    localparam int NUM_CLASSES    = 4;
    localparam int HIST_LANES     = 3;

    typedef enum logic [1:0] {
        ACT_RECORD     = 2'd0,
        ACT_READ_CLASS = 2'd1,
        ACT_READ_BIN   = 2'd2,
        ACT_CLEAR      = 2'd3
    } t_action;

    localparam logic [2:0] FT_I = 3'd1;
    localparam logic [2:0] FT_P = 3'd2;
    localparam logic [2:0] FT_B = 3'd3;
    localparam logic [2:0] FT_S = 3'd4;

    localparam logic [1:0] CLS_ALL = 2'd0;
    localparam logic [1:0] CLS_I   = 2'd1;
    localparam logic [1:0] CLS_P   = 2'd2;
    localparam logic [1:0] CLS_B   = 2'd3;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_QUANT = 2'd1;
    localparam logic [1:0] ERR_CLASS = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  frame_type;
        logic [23:0] frame_length;
        logic [4:0]  quant_value;
        logic [1:0]  stat_class;
    } t_item;

    typedef struct packed {
        logic [31:0] cnt;
        logic [4:0]  min_q;
        logic [4:0]  max_q;
        logic [23:0] min_len;
        logic [23:0] max_len;
        logic [47:0] tot_len;
    } t_cls_stat;

    typedef struct packed {
        logic        upd;
        logic        clr;
        logic [1:0]  idx;
        logic [4:0]  q;
        logic [23:0] len;
    } t_cls_ctl;

    typedef struct packed {
        logic       rec;
        logic       clr;
        logic [1:0] lane;
    } t_hist_ctl;

    typedef logic [HIST_LANES-1:0][31:0] t_row;

    typedef struct packed {
        logic [31:0] frame_count;
        logic [4:0]  least_quant;
        logic [4:0]  greatest_quant;
        logic [23:0] least_length;
        logic [23:0] greatest_length;
        logic [47:0] total_length;
        logic [31:0] bin_i;
        logic [31:0] bin_p;
        logic [31:0] bin_b;
        logic [31:0] peak_bin_total;
        logic [1:0]  error_code;
    } t_result;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

>>> rtl/fsc_if.sv
// handshake channels: frame word in, statistics word out
interface fsc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [2:0]  frame_type;
    logic [23:0] frame_length;
    logic [4:0]  quant_value;
    logic [1:0]  stat_class;

    modport source (output valid, action, frame_type, frame_length, quant_value, stat_class,
                    input ready);
    modport sink (input valid, action, frame_type, frame_length, quant_value, stat_class,
                  output ready);
endinterface

interface fsc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_count;
    logic [4:0]  least_quant;
    logic [4:0]  greatest_quant;
    logic [23:0] least_length;
    logic [23:0] greatest_length;
    logic [47:0] total_length;
    logic [31:0] bin_i;
    logic [31:0] bin_p;
    logic [31:0] bin_b;
    logic [31:0] peak_bin_total;
    logic [1:0]  error_code;

    modport source (output valid, frame_count, least_quant, greatest_quant, least_length,
                    greatest_length, total_length, bin_i, bin_p, bin_b, peak_bin_total,
                    error_code, input ready);
    modport sink (input valid, frame_count, least_quant, greatest_quant, least_length,
                  greatest_length, total_length, bin_i, bin_p, bin_b, peak_bin_total,
                  error_code, output ready);
endinterface

>>> rtl/fsc_class.sv
// per-class statistics registers with update and selection logic
module fsc_class
    import fsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cls_ctl  i_ctl,
    input  logic [1:0] i_sel,
    output t_cls_stat o_stat
);

    t_cls_stat r_cls [NUM_CLASSES];
    t_cls_stat n_cls [NUM_CLASSES];

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            logic        hit;
            logic [48:0] sum;
            hit = i_ctl.upd && ((2'(c) == CLS_ALL) || (2'(c) == i_ctl.idx));
            sum = {1'b0, r_cls[c].tot_len} + {25'd0, i_ctl.len};
            n_cls[c] = r_cls[c];
            if (hit) begin
                n_cls[c].cnt = sat_inc32(r_cls[c].cnt);
                if (r_cls[c].min_q == 5'd0 || i_ctl.q < r_cls[c].min_q) begin
                    n_cls[c].min_q = i_ctl.q;
                end
                if (r_cls[c].max_q == 5'd0 || i_ctl.q > r_cls[c].max_q) begin
                    n_cls[c].max_q = i_ctl.q;
                end
                if (r_cls[c].min_len == 24'd0 || i_ctl.len < r_cls[c].min_len) begin
                    n_cls[c].min_len = i_ctl.len;
                end
                if (r_cls[c].max_len == 24'd0 || i_ctl.len > r_cls[c].max_len) begin
                    n_cls[c].max_len = i_ctl.len;
                end
                n_cls[c].tot_len = sum[48] ? {48{1'b1}} : sum[47:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (!i_rst_n || i_ctl.clr) begin
                r_cls[c] <= '0;
            end else begin
                r_cls[c] <= n_cls[c];
            end
        end
    end

    assign o_stat = n_cls[i_sel];

    // all-frames class counts at least as many as any type class
    a_all_count_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cls[CLS_ALL].cnt >= r_cls[CLS_I].cnt) && (r_cls[CLS_ALL].cnt >= r_cls[CLS_P].cnt)
        && (r_cls[CLS_ALL].cnt >= r_cls[CLS_B].cnt))
        else $error("all-frames count below a type class count");

    a_quant_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cls[CLS_ALL].min_q <= r_cls[CLS_ALL].max_q)
        else $error("least quantizer above greatest quantizer");

    a_upd_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.upd && !i_ctl.clr && r_cls[CLS_ALL].cnt != 32'hFFFF_FFFF)
        |=> (r_cls[CLS_ALL].cnt == $past(r_cls[CLS_ALL].cnt) + 32'd1))
        else $error("recorded frame not counted");

endmodule

>>> rtl/fsc_hist.sv
// quantizer histogram memory with row forwarding and peak bin total
module fsc_hist
    import fsc_pkg::*;
#(
    parameter int QUANT_BINS = QUANT_BINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(QUANT_BINS)-1:0] i_rd_row,
    input  logic [$clog2(QUANT_BINS)-1:0] i_wr_row,
    input  t_hist_ctl                     i_ctl,
    output t_row                          o_row,
    output logic [31:0]                   o_peak
);

    t_row                  r_mem [QUANT_BINS];
    logic [QUANT_BINS-1:0] r_vld;
    t_row                  r_row;
    logic [31:0]           r_peak;

    t_row        n_row;
    logic [33:0] sum;
    logic [31:0] sum_sat;
    logic [31:0] n_peak;

    always_comb begin
        n_row = r_row;
        if (i_ctl.rec) begin
            n_row[i_ctl.lane] = sat_inc32(r_row[i_ctl.lane]);
        end
        sum = {2'b00, n_row[0]} + {2'b00, n_row[1]} + {2'b00, n_row[2]};
        sum_sat = (|sum[33:32]) ? 32'hFFFF_FFFF : sum[31:0];
        n_peak = (i_ctl.rec && sum_sat > r_peak) ? sum_sat : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rec) begin
            r_mem[i_wr_row] <= n_row;
        end
    end

    // read with bypass of a same-cycle write or clear
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_ctl.clr) begin
                r_row <= '0;
            end else if (i_ctl.rec && i_wr_row == i_rd_row) begin
                r_row <= n_row;
            end else if (r_vld[i_rd_row]) begin
                r_row <= r_mem[i_rd_row];
            end else begin
                r_row <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vld  <= '0;
            r_peak <= '0;
        end else begin
            if (i_ctl.rec) begin
                r_vld[i_wr_row] <= 1'b1;
            end
            r_peak <= n_peak;
        end
    end

    assign o_row  = n_row;
    assign o_peak = n_peak;

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_peak < $past(r_peak)) |-> $past(i_ctl.clr))
        else $error("peak bin total fell without a clear");

    a_rec_marks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.rec && !i_ctl.clr) |=> r_vld[$past(i_wr_row)])
        else $error("written histogram row not marked valid");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr |=> (r_vld == '0 && r_peak == 32'd0))
        else $error("clear left histogram state behind");

endmodule

>>> rtl/encoder_frame_stats_collector.sv
// an accepted word is held in stage 1, and its result word is registered once the result register can advance
// throughput: one word per cycle while the sink takes results, result register decouples a stalled sink
// the histogram row is read at acceptance and written back when the word retires
// reset clears all class statistics, histogram row valid flags and the peak total
// reset takes effect without a sweep of the histogram memory
module encoder_frame_stats_collector
    import fsc_pkg::*;
#(
    parameter int QUANT_BINS = QUANT_BINS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fsc_in_if.sink    i_frame,
    fsc_out_if.source o_stats
);

    localparam int ROW_AW = $clog2(QUANT_BINS);

    logic    r_s1_vld;
    t_item   r_s1;
    logic    r_out_vld;
    t_result r_out;

    logic                in_acc;
    logic                adv;
    logic                commit;
    logic [ROW_AW-1:0]   rd_row;
    logic [ROW_AW-1:0]   wr_row;
    t_action             act;
    logic                q_bad;
    logic                t_bad;
    logic                rec_ok;
    logic [1:0]          cls_idx;
    logic [1:0]          cls_sel;
    t_cls_ctl            cls_ctl;
    t_hist_ctl           hist_ctl;
    t_cls_stat           cls_stat;
    t_row                row;
    logic [31:0]         peak;
    t_result             n_out;

    assign adv    = !r_out_vld || o_stats.ready;
    assign i_frame.ready = !r_s1_vld || adv;
    assign in_acc = i_frame.valid && i_frame.ready;
    assign commit = r_s1_vld && adv;

    assign rd_row = (i_frame.quant_value != 5'd0) ? ROW_AW'(i_frame.quant_value - 5'd1) : '0;
    assign wr_row = (r_s1.quant_value != 5'd0) ? ROW_AW'(r_s1.quant_value - 5'd1) : '0;

    always_comb begin
        act   = t_action'(r_s1.action);
        q_bad = (r_s1.quant_value == 5'd0) || (32'(r_s1.quant_value) > QUANT_BINS);
        case (r_s1.frame_type)
            FT_I: begin
                t_bad   = 1'b0;
                cls_idx = CLS_I;
            end
            FT_P, FT_S: begin
                t_bad   = 1'b0;
                cls_idx = CLS_P;
            end
            FT_B: begin
                t_bad   = 1'b0;
                cls_idx = CLS_B;
            end
            default: begin
                t_bad   = 1'b1;
                cls_idx = CLS_P;
            end
        endcase
        rec_ok  = (act == ACT_RECORD) && !q_bad && !t_bad;
        cls_sel = (act == ACT_RECORD) ? cls_idx : r_s1.stat_class;

        cls_ctl.upd  = commit && rec_ok;
        cls_ctl.clr  = commit && (act == ACT_CLEAR);
        cls_ctl.idx  = cls_idx;
        cls_ctl.q    = r_s1.quant_value;
        cls_ctl.len  = r_s1.frame_length;

        hist_ctl.rec  = commit && rec_ok;
        hist_ctl.clr  = commit && (act == ACT_CLEAR);
        hist_ctl.lane = cls_idx - 2'd1;
    end

    fsc_class u_class (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cls_ctl),
        .i_sel   (cls_sel),
        .o_stat  (cls_stat)
    );

    fsc_hist #(
        .QUANT_BINS (QUANT_BINS)
    ) u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_acc),
        .i_rd_row (rd_row),
        .i_wr_row (wr_row),
        .i_ctl    (hist_ctl),
        .o_row    (row),
        .o_peak   (peak)
    );

    always_comb begin
        n_out = '0;
        case (act)
            ACT_RECORD: begin
                if (q_bad) begin
                    n_out.error_code = ERR_QUANT;
                end else if (t_bad) begin
                    n_out.error_code = ERR_CLASS;
                end else begin
                    n_out.frame_count     = cls_stat.cnt;
                    n_out.least_quant     = cls_stat.min_q;
                    n_out.greatest_quant  = cls_stat.max_q;
                    n_out.least_length    = cls_stat.min_len;
                    n_out.greatest_length = cls_stat.max_len;
                    n_out.total_length    = cls_stat.tot_len;
                    n_out.bin_i           = row[0];
                    n_out.bin_p           = row[1];
                    n_out.bin_b           = row[2];
                    n_out.peak_bin_total  = peak;
                end
            end
            ACT_READ_CLASS: begin
                n_out.frame_count     = cls_stat.cnt;
                n_out.least_quant     = cls_stat.min_q;
                n_out.greatest_quant  = cls_stat.max_q;
                n_out.least_length    = cls_stat.min_len;
                n_out.greatest_length = cls_stat.max_len;
                n_out.total_length    = cls_stat.tot_len;
                n_out.peak_bin_total  = peak;
            end
            ACT_READ_BIN: begin
                if (q_bad) begin
                    n_out.error_code = ERR_QUANT;
                end else begin
                    n_out.bin_i          = row[0];
                    n_out.bin_p          = row[1];
                    n_out.bin_b          = row[2];
                    n_out.peak_bin_total = peak;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_frame.ready) begin
                r_s1_vld <= i_frame.valid;
            end
            if (adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.action       <= i_frame.action;
            r_s1.frame_type   <= i_frame.frame_type;
            r_s1.frame_length <= i_frame.frame_length;
            r_s1.quant_value  <= i_frame.quant_value;
            r_s1.stat_class   <= i_frame.stat_class;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign o_stats.valid           = r_out_vld;
    assign o_stats.frame_count     = r_out.frame_count;
    assign o_stats.least_quant     = r_out.least_quant;
    assign o_stats.greatest_quant  = r_out.greatest_quant;
    assign o_stats.least_length    = r_out.least_length;
    assign o_stats.greatest_length = r_out.greatest_length;
    assign o_stats.total_length    = r_out.total_length;
    assign o_stats.bin_i           = r_out.bin_i;
    assign o_stats.bin_p           = r_out.bin_p;
    assign o_stats.bin_b           = r_out.bin_b;
    assign o_stats.peak_bin_total  = r_out.peak_bin_total;
    assign o_stats.error_code      = r_out.error_code;

    a_retire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_stats.valid)
        else $error("retired word did not reach the result register");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stats.valid && o_stats.error_code != ERR_OK) |-> (o_stats.peak_bin_total == 32'd0))
        else $error("error word carries a peak total");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stats.valid && !o_stats.ready) |=> (o_stats.valid && $stable(r_out)))
        else $error("stalled stats word changed");

endmodule

>>> tb/sv/tb.sv
// testbench of the encoder frame statistics collector: directed and random frame words against a predictor
`timescale 1ns / 1ps

module tb;
    import fsc_pkg::*;

    localparam int QBINS = QUANT_BINS_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fsc_in_if  frame_if ();
    fsc_out_if stats_if ();

    encoder_frame_stats_collector DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_if),
        .o_stats (stats_if)
    );

    // predictor state
    logic [31:0] cls_count   [NUM_CLASSES];
    logic [4:0]  cls_min_q   [NUM_CLASSES];
    logic [4:0]  cls_max_q   [NUM_CLASSES];
    logic [23:0] cls_min_len [NUM_CLASSES];
    logic [23:0] cls_max_len [NUM_CLASSES];
    logic [47:0] cls_tot_len [NUM_CLASSES];
    logic [31:0] quant_hist  [HIST_LANES*QBINS];
    logic [31:0] peak_sum;

    t_item   pending_frames [$];
    t_result expected_stats [$];

    int   mismatches;
    logic frame_taken;
    int   burst_left;
    int   gap_left;
    int   rx_cycle;
    int   rx_mode;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void clear_stats();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            cls_count[c]   = '0;
            cls_min_q[c]   = '0;
            cls_max_q[c]   = '0;
            cls_min_len[c] = '0;
            cls_max_len[c] = '0;
            cls_tot_len[c] = '0;
        end
        for (int k = 0; k < HIST_LANES*QBINS; k++) quant_hist[k] = '0;
        peak_sum = '0;
    endfunction

    function automatic void fold_frame(input logic [1:0] c, input logic [4:0] q,
                                       input logic [23:0] len);
        logic [48:0] acc;
        cls_count[c] = (cls_count[c] == 32'hFFFF_FFFF) ? cls_count[c] : cls_count[c] + 32'd1;
        if (cls_min_q[c] == 0 || q < cls_min_q[c]) cls_min_q[c] = q;
        if (cls_max_q[c] == 0 || q > cls_max_q[c]) cls_max_q[c] = q;
        if (cls_min_len[c] == 0 || len < cls_min_len[c]) cls_min_len[c] = len;
        if (cls_max_len[c] == 0 || len > cls_max_len[c]) cls_max_len[c] = len;
        acc = {1'b0, cls_tot_len[c]} + {25'd0, len};
        cls_tot_len[c] = acc[48] ? 48'hFFFF_FFFF_FFFF : acc[47:0];
    endfunction

    function automatic void load_class(inout t_result r, input logic [1:0] c);
        r.frame_count     = cls_count[c];
        r.least_quant     = cls_min_q[c];
        r.greatest_quant  = cls_max_q[c];
        r.least_length    = cls_min_len[c];
        r.greatest_length = cls_max_len[c];
        r.total_length    = cls_tot_len[c];
    endfunction

    function automatic void load_bins(inout t_result r, input int b);
        r.bin_i = quant_hist[b];
        r.bin_p = quant_hist[QBINS + b];
        r.bin_b = quant_hist[2*QBINS + b];
    endfunction

    function automatic t_result predict_stats(input t_item it);
        t_result     r;
        logic [2:0]  ft;
        int          b;
        int          slot;
        logic [33:0] sum;
        r = '0;
        case (t_action'(it.action))
            ACT_RECORD: begin
                if (it.quant_value == 0 || it.quant_value > QBINS) begin
                    r.error_code = ERR_QUANT;
                end else if (it.frame_type < FT_I || it.frame_type > FT_S) begin
                    r.error_code = ERR_CLASS;
                end else begin
                    ft = (it.frame_type == FT_S) ? FT_P : it.frame_type;
                    b = int'(it.quant_value) - 1;
                    fold_frame(CLS_ALL, it.quant_value, it.frame_length);
                    fold_frame(ft[1:0], it.quant_value, it.frame_length);
                    slot = (int'(ft) - 1) * QBINS + b;
                    if (quant_hist[slot] != 32'hFFFF_FFFF) quant_hist[slot] = quant_hist[slot] + 1;
                    sum = {2'b0, quant_hist[b]} + {2'b0, quant_hist[QBINS + b]}
                        + {2'b0, quant_hist[2*QBINS + b]};
                    if (sum > 34'h0_FFFF_FFFF) sum = 34'h0_FFFF_FFFF;
                    if (sum[31:0] > peak_sum) peak_sum = sum[31:0];
                    load_class(r, ft[1:0]);
                    load_bins(r, b);
                    r.peak_bin_total = peak_sum;
                end
            end
            ACT_READ_CLASS: begin
                load_class(r, it.stat_class);
                r.peak_bin_total = peak_sum;
            end
            ACT_READ_BIN: begin
                if (it.quant_value == 0 || it.quant_value > QBINS) begin
                    r.error_code = ERR_QUANT;
                end else begin
                    load_bins(r, int'(it.quant_value) - 1);
                    r.peak_bin_total = peak_sum;
                end
            end
            default: begin
                clear_stats();
            end
        endcase
        return r;
    endfunction

    function automatic t_item make_item(input t_action act, input logic [2:0] ft,
                                        input logic [23:0] len, input logic [4:0] q,
                                        input logic [1:0] cls);
        t_item it;
        it.action       = act;
        it.frame_type   = ft;
        it.frame_length = len;
        it.quant_value  = q;
        it.stat_class   = cls;
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // frame word driver
    always @(negedge i_clk) begin : drive_frames
        t_item nxt;
        if (!i_rst_n) begin
            frame_if.valid <= 1'b0;
        end else if (!frame_if.valid || frame_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                frame_if.valid <= 1'b0;
            end else if (pending_frames.size() != 0) begin
                nxt = pending_frames.pop_front();
                frame_if.action       <= nxt.action;
                frame_if.frame_type   <= nxt.frame_type;
                frame_if.frame_length <= nxt.frame_length;
                frame_if.quant_value  <= nxt.quant_value;
                frame_if.stat_class   <= nxt.stat_class;
                frame_if.valid        <= 1'b1;
                if (burst_left <= 1) begin
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left <= $urandom_range(20, 60);
                        gap_left   <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= $urandom_range(0, 8);
                    end
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                frame_if.valid <= 1'b0;
            end
        end
    end

    // stats word receiver stall pattern
    always @(negedge i_clk) begin : drive_ready
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 63) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       stats_if.ready <= 1'b1;
            1:       stats_if.ready <= 1'($urandom_range(0, 1));
            2:       stats_if.ready <= (rx_cycle % 4 != 0);
            default: stats_if.ready <= (rx_cycle % 8 == 7);
        endcase
    end

    // acceptance, prediction and result checking
    always @(posedge i_clk) begin : watch_words
        t_result want;
        frame_taken <= i_rst_n && frame_if.valid && frame_if.ready;
        if (i_rst_n && frame_if.valid && frame_if.ready) begin
            expected_stats.push_back(predict_stats(make_item(t_action'(frame_if.action),
                frame_if.frame_type, frame_if.frame_length, frame_if.quant_value,
                frame_if.stat_class)));
        end
        if (i_rst_n && stats_if.valid === 1'b1 && stats_if.ready) begin
            if (expected_stats.size() == 0) begin
                report_mismatch("stats word with nothing expected");
            end else begin
                want = expected_stats.pop_front();
                check_field("frame_count", 48'(stats_if.frame_count),
                            48'(want.frame_count));
                check_field("least_quant", 48'(stats_if.least_quant),
                            48'(want.least_quant));
                check_field("greatest_quant", 48'(stats_if.greatest_quant),
                            48'(want.greatest_quant));
                check_field("least_length", 48'(stats_if.least_length),
                            48'(want.least_length));
                check_field("greatest_length", 48'(stats_if.greatest_length),
                            48'(want.greatest_length));
                check_field("total_length", stats_if.total_length, want.total_length);
                check_field("bin_i", 48'(stats_if.bin_i), 48'(want.bin_i));
                check_field("bin_p", 48'(stats_if.bin_p), 48'(want.bin_p));
                check_field("bin_b", 48'(stats_if.bin_b), 48'(want.bin_b));
                check_field("peak_bin_total", 48'(stats_if.peak_bin_total),
                            48'(want.peak_bin_total));
                check_field("error_code", 48'(stats_if.error_code),
                            48'(want.error_code));
            end
        end
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int          r;
        logic [2:0]  ft;
        logic [4:0]  q;
        logic [23:0] len;
        mismatches  = 0;
        frame_taken = 1'b0;
        burst_left  = 1;
        gap_left    = 0;
        rx_cycle    = 0;
        rx_mode     = 0;
        i_rst_n     = 1'b0;
        frame_if.valid        = 1'b0;
        frame_if.action       = ACT_RECORD;
        frame_if.frame_type   = '0;
        frame_if.frame_length = '0;
        frame_if.quant_value  = '0;
        frame_if.stat_class   = '0;
        stats_if.ready        = 1'b0;
        clear_stats();

        // directed: reset state, extremes, errors, clear, zero length
        pending_frames.push_back(make_item(ACT_READ_CLASS, FT_I, 24'd0, 5'd0, CLS_ALL));
        pending_frames.push_back(make_item(ACT_READ_BIN, FT_I, 24'd0, 5'd1, CLS_ALL));
        pending_frames.push_back(make_item(ACT_RECORD, FT_I, 24'd0, 5'd1, CLS_ALL));
        pending_frames.push_back(make_item(ACT_RECORD, FT_P, 24'hFF_FFFF, 5'd31, CLS_B));
        pending_frames.push_back(make_item(ACT_RECORD, FT_B, 24'd1, 5'd16, CLS_I));
        pending_frames.push_back(make_item(ACT_RECORD, FT_S, 24'd100, 5'd5, CLS_P));
        pending_frames.push_back(make_item(ACT_RECORD, FT_I, 24'd77, 5'd1, CLS_ALL));
        pending_frames.push_back(make_item(ACT_RECORD, 3'd0, 24'd5, 5'd0, CLS_ALL));
        pending_frames.push_back(make_item(ACT_RECORD, 3'd0, 24'd5, 5'd3, CLS_ALL));
        pending_frames.push_back(make_item(ACT_RECORD, 3'd5, 24'd5, 5'd3, CLS_ALL));
        pending_frames.push_back(make_item(ACT_RECORD, 3'd7, 24'hFF_FFFF, 5'd31, CLS_B));
        pending_frames.push_back(make_item(ACT_READ_BIN, 3'd7, 24'hFF_FFFF, 5'd0, CLS_B));
        pending_frames.push_back(make_item(ACT_READ_BIN, FT_P, 24'd0, 5'd31, CLS_ALL));
        pending_frames.push_back(make_item(ACT_READ_CLASS, FT_B, 24'd0, 5'd0, CLS_I));
        pending_frames.push_back(make_item(ACT_READ_CLASS, FT_B, 24'd0, 5'd0, CLS_P));
        pending_frames.push_back(make_item(ACT_READ_CLASS, 3'd7, 24'hFF_FFFF, 5'd31, CLS_B));
        pending_frames.push_back(make_item(ACT_READ_CLASS, FT_I, 24'd0, 5'd0, CLS_ALL));
        pending_frames.push_back(make_item(ACT_CLEAR, 3'd7, 24'hFF_FFFF, 5'd31, CLS_B));
        pending_frames.push_back(make_item(ACT_READ_CLASS, FT_I, 24'd0, 5'd0, CLS_ALL));
        pending_frames.push_back(make_item(ACT_READ_BIN, FT_I, 24'd0, 5'd31, CLS_ALL));
        pending_frames.push_back(make_item(ACT_RECORD, FT_I, 24'd5, 5'd9, CLS_ALL));
        pending_frames.push_back(make_item(ACT_RECORD, FT_I, 24'd0, 5'd9, CLS_ALL));
        pending_frames.push_back(make_item(ACT_RECORD, FT_I, 24'd8, 5'd9, CLS_ALL));
        pending_frames.push_back(make_item(ACT_READ_CLASS, FT_I, 24'd0, 5'd0, CLS_I));

        // random: mostly well-formed frames, some noise, reads and rare clears
        for (int n = 0; n < 500; n++) begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 5))
                0:       len = 24'd0;
                1:       len = 24'hFF_FFFF;
                2:       len = 24'($urandom_range(0, 255));
                default: len = 24'($urandom);
            endcase
            ft = 3'($urandom_range(FT_I, FT_S));
            q  = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(1, 6))
                                             : 5'($urandom_range(1, QBINS));
            if (r < 60) begin
                pending_frames.push_back(make_item(ACT_RECORD, ft, len, q, 2'($urandom)));
            end else if (r < 70) begin
                pending_frames.push_back(make_item(ACT_RECORD, 3'($urandom), len,
                                                   5'($urandom), 2'($urandom)));
            end else if (r < 83) begin
                pending_frames.push_back(make_item(ACT_READ_CLASS, 3'($urandom), len,
                                                   5'($urandom), 2'($urandom)));
            end else if (r < 98) begin
                pending_frames.push_back(make_item(ACT_READ_BIN, 3'($urandom), len,
                                                   5'($urandom), 2'($urandom)));
            end else begin
                pending_frames.push_back(make_item(ACT_CLEAR, 3'($urandom), len,
                                                   5'($urandom), 2'($urandom)));
            end
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_frames.size() != 0 || frame_if.valid === 1'b1
               || expected_stats.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
